FILE: hdl/rawf_pkg.sv
// Shared constants, types and helper functions of the register ALU with flags.
package rawf_pkg;

	localparam int REGISTER_COUNT = 8;
	localparam int DATA_WIDTH     = 32;
	localparam int IDX_W          = $clog2(REGISTER_COUNT);
	localparam int FIELD_IDX_W    = 3;
	localparam int OPCODE_W       = 8;
	localparam int FLAG_W         = 4;
	localparam int COUNT_W        = $clog2(DATA_WIDTH);
	localparam int S_TDATA_W      = 16;
	localparam int M_TDATA_W      = 40;

	typedef logic [DATA_WIDTH-1:0] word_t;
	typedef logic [OPCODE_W-1:0]   opcode_t;
	typedef logic [IDX_W-1:0]      idx_t;

	localparam opcode_t OP_ADD = 8'h02;
	localparam opcode_t OP_SUB = 8'h03;
	localparam opcode_t OP_MUL = 8'h04;
	localparam opcode_t OP_DIV = 8'h05;
	localparam opcode_t OP_MOD = 8'h06;
	localparam opcode_t OP_END = 8'h20;

	// flag bit positions
	localparam int FLAG_CARRY = 3;
	localparam int FLAG_OVF   = 2;
	localparam int FLAG_SIGN  = 1;
	localparam int FLAG_ZERO  = 0;

	localparam word_t SIGN_MIN = word_t'(1) << (DATA_WIDTH - 1);

	typedef struct packed {
		opcode_t opcode;
		word_t   a;
		word_t   b;
	} exec_req_t;

	typedef struct packed {
		word_t result;
		logic  carry;
		logic  ovf;
	} exec_rsp_t;

	function automatic logic is_arith(opcode_t op);
		return (op >= OP_ADD) && (op <= OP_MOD);
	endfunction

	function automatic idx_t reg_index(logic [FIELD_IDX_W-1:0] f);
		return IDX_W'(f % REGISTER_COUNT);
	endfunction

	function automatic word_t reset_value(idx_t idx);
		word_t v;
		case (idx)
			IDX_W'(0): v = DATA_WIDTH'(64'h1111_1111);
			IDX_W'(1): v = DATA_WIDTH'(64'h1111_1111);
			IDX_W'(2): v = DATA_WIDTH'(64'h0000_1111);
			IDX_W'(3): v = DATA_WIDTH'(64'h1111_0000);
			IDX_W'(4): v = DATA_WIDTH'(64'd4);
			IDX_W'(5): v = DATA_WIDTH'(64'd5);
			default:   v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: hdl/rawf_ram.sv
// Generic RAM: one write port, two registered read ports.
module rawf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata0 <= mem_q[raddr0];
			rdata1 <= mem_q[raddr1];
		end
	end

endmodule

FILE: hdl/rawf_exec.sv
// Iterative execution unit: one shared add/subtract used by every operation.
module rawf_exec (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  rawf_pkg::exec_req_t req,
	output logic                done,
	output rawf_pkg::exec_rsp_t rsp
);

	localparam int W = rawf_pkg::DATA_WIDTH;
	localparam logic [rawf_pkg::COUNT_W-1:0] LAST = rawf_pkg::COUNT_W'(W - 1);

	typedef enum logic [4:0] {
		E_IDLE  = 5'b00001,
		E_FIRST = 5'b00010,
		E_MAGB  = 5'b00100,
		E_LOOP  = 5'b01000,
		E_FINAL = 5'b10000
	} exec_state_t;

	exec_state_t                    state_q, state_d;
	logic [rawf_pkg::COUNT_W-1:0]   cnt_q, cnt_d;
	logic                           done_q, done_d;
	rawf_pkg::opcode_t              op_q;
	rawf_pkg::word_t                a_q, b_q, acc_q, lo_q, res_q;
	logic                           neg_q, carry_q, ovf_q;

	rawf_pkg::word_t add_x, add_y;
	logic            add_sub, add_sx;
	logic [W:0]      sum;
	logic            quick, fits;

	// shared adder operand select
	always_comb begin
		add_x   = '0;
		add_y   = '0;
		add_sub = 1'b0;
		add_sx  = 1'b0;
		case (state_q)
			E_FIRST: begin
				add_x = a_q;
				add_y = b_q;
				case (op_q)
					rawf_pkg::OP_ADD: add_sub = 1'b0;
					rawf_pkg::OP_SUB: add_sub = 1'b1;
					rawf_pkg::OP_MUL: begin
						add_x   = '0;
						add_y   = a_q;
						add_sub = 1'b1;
					end
					default: begin
						add_sub = 1'b1;
						add_sx  = 1'b1;
					end
				endcase
			end
			E_MAGB: begin
				add_y   = b_q;
				add_sub = 1'b1;
			end
			E_LOOP: begin
				if (op_q == rawf_pkg::OP_MUL) begin
					add_x = acc_q;
					add_y = a_q;
				end else begin
					add_x   = {acc_q[W-2:0], lo_q[W-1]};
					add_y   = b_q;
					add_sub = 1'b1;
				end
			end
			E_FINAL: begin
				add_y   = lo_q;
				add_sub = 1'b1;
			end
			default: ;
		endcase
	end

	assign sum = {add_sx & add_x[W-1], add_x}
	           + ({add_sx & add_y[W-1], add_y} ^ {(W+1){add_sub}})
	           + (W+1)'(add_sub);

	// divide shortcut: src zero, negative, or greater than dest (signed)
	assign quick = (b_q == '0) || b_q[W-1] || sum[W];

	assign fits = (acc_q == '0) &&
	              (neg_q ? (!lo_q[W-1] || (lo_q == rawf_pkg::SIGN_MIN)) : !lo_q[W-1]);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		done_d  = 1'b0;
		case (state_q)
			E_IDLE: begin
				if (start) begin
					state_d = E_FIRST;
				end
			end
			E_FIRST: begin
				cnt_d = '0;
				case (op_q)
					rawf_pkg::OP_MUL: state_d = E_MAGB;
					rawf_pkg::OP_DIV, rawf_pkg::OP_MOD: begin
						if (quick) begin
							state_d = E_IDLE;
							done_d  = 1'b1;
						end else begin
							state_d = E_LOOP;
						end
					end
					default: begin
						state_d = E_IDLE;
						done_d  = 1'b1;
					end
				endcase
			end
			E_MAGB: begin
				state_d = E_LOOP;
			end
			E_LOOP: begin
				if (cnt_q == LAST) begin
					state_d = E_FINAL;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			E_FINAL: begin
				state_d = E_IDLE;
				done_d  = 1'b1;
			end
			default: state_d = E_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			E_IDLE: begin
				if (start) begin
					a_q   <= req.a;
					b_q   <= req.b;
					op_q  <= req.opcode;
					neg_q <= req.a[W-1] ^ req.b[W-1];
				end
			end
			E_FIRST: begin
				case (op_q)
					rawf_pkg::OP_ADD: begin
						res_q   <= sum[W-1:0];
						carry_q <= sum[W];
						ovf_q   <= (a_q[W-1] ^ sum[W-1]) & (b_q[W-1] ^ sum[W-1]);
					end
					rawf_pkg::OP_SUB: begin
						res_q   <= sum[W-1:0];
						carry_q <= ~sum[W];
						ovf_q   <= (a_q[W-1] ^ b_q[W-1]) & (a_q[W-1] ^ sum[W-1]);
					end
					rawf_pkg::OP_MUL: begin
						if (a_q[W-1]) begin
							a_q <= sum[W-1:0];
						end
						acc_q   <= '0;
						carry_q <= 1'b0;
					end
					rawf_pkg::OP_DIV, rawf_pkg::OP_MOD: begin
						lo_q    <= a_q;
						acc_q   <= '0;
						carry_q <= 1'b0;
						ovf_q   <= 1'b0;
						res_q   <= (op_q == rawf_pkg::OP_DIV) ? '0 : a_q;
					end
					default: begin
						res_q   <= '0;
						carry_q <= 1'b0;
						ovf_q   <= 1'b0;
					end
				endcase
			end
			E_MAGB: begin
				lo_q <= b_q[W-1] ? sum[W-1:0] : b_q;
			end
			E_LOOP: begin
				if (op_q == rawf_pkg::OP_MUL) begin
					// shift-add on magnitudes, 2W-bit product in {acc, lo}
					if (lo_q[0]) begin
						acc_q <= sum[W:1];
						lo_q  <= {sum[0], lo_q[W-1:1]};
					end else begin
						acc_q <= {1'b0, acc_q[W-1:1]};
						lo_q  <= {acc_q[0], lo_q[W-1:1]};
					end
				end else begin
					// restoring division: remainder in acc, quotient shifts into lo
					acc_q <= sum[W] ? add_x : sum[W-1:0];
					lo_q  <= {lo_q[W-2:0], ~sum[W]};
				end
			end
			E_FINAL: begin
				case (op_q)
					rawf_pkg::OP_MUL: begin
						res_q <= neg_q ? sum[W-1:0] : lo_q;
						ovf_q <= !fits;
					end
					rawf_pkg::OP_DIV: res_q <= lo_q;
					default:          res_q <= acc_q;
				endcase
			end
			default: ;
		endcase
	end

	assign done       = done_q;
	assign rsp.result = res_q;
	assign rsp.carry  = carry_q;
	assign rsp.ovf    = ovf_q;

endmodule

FILE: hdl/register_alu_with_flags_unit.sv
// Top level: register ALU with flags, stream in, stream out.
//
//  channel | dir | fields (low bit up)                                  | width
//  --------+-----+------------------------------------------------------+------
//  s_*     | in  | tdata: opcode[7:0] dest_index[10:8] src_index[13:11]  | 16
//  m_*     | out | tdata: result_value[31:0] flag_bits[35:32]           | 40
//          |     | tuser: wrote_register   tlast: end_seen              |
//
// Items are handled one at a time. No-op / end skip rawf_exec; add / sub
//   and div / mod with a trivial quotient finish in its first state, while
//   other div / mod and mul loop on the shared adder in rawf_exec: one
//   product or quotient bit per cycle, plus operand sign fixups.
// Reset loads the register file's initial values through per-entry valid
// bits and clears the flags at once; no clearing pass.
// A result waits in the output register; s_tready is high whenever the
// sequencer is idle, even while m_tvalid waits for m_tready.
module register_alu_with_flags_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [rawf_pkg::S_TDATA_W-1:0]    s_tdata,  // opcode, dest_index, src_index
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rawf_pkg::M_TDATA_W-1:0]    m_tdata,  // result_value, flag_bits
	output logic                              m_tlast,  // end_seen
	output logic                              m_tuser   // wrote_register
);

	localparam int W  = rawf_pkg::DATA_WIDTH;
	localparam int FI = rawf_pkg::FIELD_IDX_W;
	localparam int OW = rawf_pkg::OPCODE_W;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_READ  = 4'b0010,
		S_EXEC  = 4'b0100,
		S_WRITE = 4'b1000
	} top_state_t;

	top_state_t state_q, state_d;

	rawf_pkg::opcode_t                  opcode_q;
	rawf_pkg::idx_t                     dest_q, src_q;
	rawf_pkg::idx_t                     rd_dest, rd_src;
	logic [rawf_pkg::REGISTER_COUNT-1:0] vld_q;
	logic [rawf_pkg::FLAG_W-1:0]        flags_q, flags_new;
	rawf_pkg::word_t                    rdata0, rdata1, result;

	logic                               m_tvalid_q;
	logic [rawf_pkg::M_TDATA_W-1:0]     m_tdata_q;
	logic                               m_tlast_q, m_tuser_q;

	logic                  accept, out_free, wrote, exec_start, exec_done, ram_we;
	rawf_pkg::exec_req_t   req;
	rawf_pkg::exec_rsp_t   rsp;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign rd_dest = rawf_pkg::reg_index(s_tdata[OW+FI-1:OW]);
	assign rd_src  = rawf_pkg::reg_index(s_tdata[OW+2*FI-1:OW+FI]);

	assign wrote      = rawf_pkg::is_arith(opcode_q);
	assign exec_start = (state_q == S_READ) && wrote;
	assign ram_we     = (state_q == S_WRITE) && out_free && wrote;

	// never-written entries read as their reset value
	assign req.opcode = opcode_q;
	assign req.a      = vld_q[dest_q] ? rdata0 : rawf_pkg::reset_value(dest_q);
	assign req.b      = vld_q[src_q]  ? rdata1 : rawf_pkg::reset_value(src_q);

	assign result = wrote ? rsp.result : '0;

	always_comb begin
		flags_new = flags_q;
		if (wrote) begin
			flags_new[rawf_pkg::FLAG_CARRY] = rsp.carry;
			flags_new[rawf_pkg::FLAG_OVF]   = rsp.ovf;
			flags_new[rawf_pkg::FLAG_SIGN]  = result[W-1];
			flags_new[rawf_pkg::FLAG_ZERO]  = (result == '0);
		end
	end

	rawf_ram #(
		.WIDTH(rawf_pkg::DATA_WIDTH),
		.DEPTH(rawf_pkg::REGISTER_COUNT)
	) u_regs (
		.clk   (clk),
		.we    (ram_we),
		.waddr (dest_q),
		.wdata (rsp.result),
		.re    (accept),
		.raddr0(rd_dest),
		.raddr1(rd_src),
		.rdata0(rdata0),
		.rdata1(rdata1)
	);

	rawf_exec u_exec (
		.clk   (clk),
		.arst_n(arst_n),
		.start (exec_start),
		.req   (req),
		.done  (exec_done),
		.rsp   (rsp)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (accept) state_d = S_READ;
			S_READ:  state_d = wrote ? S_EXEC : S_WRITE;
			S_EXEC:  if (exec_done) state_d = S_WRITE;
			S_WRITE: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
			vld_q      <= '0;
			flags_q    <= '0;
		end else begin
			state_q <= state_d;
			// a new item replaces one taken in the same cycle
			if ((state_q == S_WRITE) && out_free) begin
				m_tvalid_q <= 1'b1;
				flags_q    <= flags_new;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (ram_we) begin
				vld_q[dest_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_q <= s_tdata[OW-1:0];
			dest_q   <= rd_dest;
			src_q    <= rd_src;
		end
		if ((state_q == S_WRITE) && out_free) begin
			m_tdata_q <= rawf_pkg::M_TDATA_W'({flags_new, result});
			m_tlast_q <= (opcode_q == rawf_pkg::OP_END);
			m_tuser_q <= wrote;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

endmodule

FILE: hdl/rawf_check.sv
// Port-level checker for the register ALU, bound to the top level.
module rawf_check (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [rawf_pkg::S_TDATA_W-1:0] s_tdata,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [rawf_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                           m_tlast,
	input logic                           m_tuser
);

	localparam int W = rawf_pkg::DATA_WIDTH;

	// one item at a time: ready drops right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in flight");

	a_noop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (m_tdata[W-1:0] == '0))
		else $error("no-op item carries a nonzero result");

	a_end_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> !m_tuser)
		else $error("end item reports a register write");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |->
			(m_tdata[W + rawf_pkg::FLAG_ZERO] == (m_tdata[W-1:0] == '0)) &&
			(m_tdata[W + rawf_pkg::FLAG_SIGN] == m_tdata[W-1]))
		else $error("zero or sign flag disagrees with the result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output item changed");

endmodule

bind register_alu_with_flags_unit rawf_check u_rawf_check (.*);

FILE: tb/sv/register_alu_with_flags_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the register ALU with flags: instruction stream in, results checked.
module register_alu_with_flags_unit_tb;
	import rawf_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;  // slowest legal run is far below this
	localparam int DRAIN_CYCLES = 60;      // longer than the slowest instruction (mul)
	localparam int IDLE_PCT     = 26;
	localparam int RANDOM_ITEMS = 450;
	localparam int MSB          = DATA_WIDTH - 1;
	localparam int PAD_W        = S_TDATA_W - OPCODE_W - 2 * FIELD_IDX_W;

	typedef logic [FIELD_IDX_W-1:0] reg_field_t;
	typedef logic [FLAG_W-1:0]      flags_t;

	// one predicted output item
	typedef struct packed {
		word_t  value;
		logic   wrote;
		flags_t flags;
		logic   done;
	} alu_out_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;  // opcode, dest_index, src_index
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;        // result_value, flag_bits
	logic                 m_tlast;        // end_seen
	logic                 m_tuser;        // wrote_register

	// predictor state: the bench's own register file and flags
	word_t    gpr [REGISTER_COUNT];
	flags_t   flag_state;
	alu_out_t expected_q [$];

	int mismatches = 0;
	int cycles     = 0;
	bit steady     = 1'b0;  // when set, neither side idles

	register_alu_with_flags_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Receiver back-pressure: random stalls except during the steady stretch.
	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99, 0) >= IDLE_PCT);
	end

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH at cycle %0d: %s got %h expected %h", cycles, what, got, want);
		mismatches++;
	endtask

	// Register file contents and flags right after reset.
	task automatic load_power_on_state();
		for (int i = 0; i < REGISTER_COUNT; i++) begin
			gpr[i] = '0;
		end
		gpr[0] = 32'h1111_1111;
		gpr[1] = 32'h1111_1111;
		gpr[2] = 32'h0000_1111;
		gpr[3] = 32'h1111_0000;
		gpr[4] = 32'd4;
		gpr[5] = 32'd5;
		flag_state = '0;
	endtask

	// Apply one instruction to the bench's copy of the state; return the item the
	// block should emit for it.
	function automatic alu_out_t execute(opcode_t op, reg_field_t dst_f, reg_field_t src_f);
		int       d;
		int       s;
		word_t    a;
		word_t    b;
		word_t    res;
		logic     carry;
		logic     ovf;
		logic     wrote;
		longint   prod;
		alu_out_t o;
		d     = int'(dst_f) % REGISTER_COUNT;
		s     = int'(src_f) % REGISTER_COUNT;
		a     = gpr[d];
		b     = gpr[s];
		res   = '0;
		carry = 1'b0;
		ovf   = 1'b0;
		wrote = 1'b1;
		case (op)
			OP_ADD: begin
				{carry, res} = {1'b0, a} + {1'b0, b};
				ovf = (a[MSB] == b[MSB]) && (res[MSB] != a[MSB]);
			end
			OP_SUB: begin
				res   = a - b;
				carry = (a >= b);  // carry means no borrow
				ovf   = (a[MSB] != b[MSB]) && (res[MSB] != a[MSB]);
			end
			OP_MUL: begin
				// full signed product in 64 bits, overflow if it does not sign-extend
				prod = longint'($signed(a)) * longint'($signed(b));
				res  = prod[MSB:0];
				ovf  = (prod != longint'($signed(res)));
			end
			OP_DIV, OP_MOD: begin
				// zero or negative divisor, or divisor above dividend: no real quotient
				if (b == '0 || b[MSB] || ($signed(b) > $signed(a)))
					res = (op == OP_DIV) ? '0 : a;
				else
					res = (op == OP_DIV) ? a / b : a % b;
			end
			default: wrote = 1'b0;
		endcase
		if (wrote) begin
			gpr[d] = res;
			flag_state = '0;
			flag_state[FLAG_CARRY] = carry;
			flag_state[FLAG_OVF]   = ovf;
			flag_state[FLAG_SIGN]  = res[MSB];
			flag_state[FLAG_ZERO]  = (res == '0);
		end
		o.value = res;
		o.wrote = wrote;
		o.flags = flag_state;
		o.done  = (op == OP_END);
		return o;
	endfunction

	// Send one instruction. Valid is left high after the handshake so the next call
	// can keep it up without a drop; idle cycles put junk on tdata.
	task automatic send_instr(opcode_t op, reg_field_t dst, reg_field_t src);
		while (!steady && $urandom_range(99, 0) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			s_tdata  <= S_TDATA_W'($urandom);
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{PAD_W{1'b0}}, src, dst, op};
		do @(posedge clk); while (!s_tready);
		expected_q.push_back(execute(op, dst, src));
	endtask

	// Sender goes quiet until every outstanding result is back.
	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	// Compare every accepted output item against the oldest prediction.
	always @(posedge clk) begin : check_out
		alu_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("result with nothing pending", 64'(m_tdata), 64'd0);
			end else begin
				want = expected_q.pop_front();
				if (m_tdata[MSB:0] !== want.value)
					report_mismatch("result_value", 64'(m_tdata[MSB:0]), 64'(want.value));
				if (m_tdata[DATA_WIDTH +: FLAG_W] !== want.flags)
					report_mismatch("flag_bits", 64'(m_tdata[DATA_WIDTH +: FLAG_W]),
						64'(want.flags));
				if (m_tuser !== want.wrote)
					report_mismatch("wrote_register", 64'(m_tuser), 64'(want.wrote));
				if (m_tlast !== want.done)
					report_mismatch("end_seen", 64'(m_tlast), 64'(want.done));
			end
		end
	end

	// Adding the still-zero r6 to r0..r5 exposes each power-on value.
	task automatic test_reset_values();
		for (int i = 0; i < 6; i++) begin
			send_instr(OP_ADD, reg_field_t'(i), reg_field_t'(6));
		end
	endtask

	// Edge cases of each arithmetic operation, in an order that builds the operands.
	task automatic test_arith_corners();
		send_instr(OP_MOD, 0, 7);  // divisor zero: dest kept
		send_instr(OP_DIV, 1, 4);  // plain divide
		send_instr(OP_MOD, 2, 5);  // plain modulo
		send_instr(OP_SUB, 7, 5);  // borrow, negative result
		send_instr(OP_DIV, 3, 7);  // negative divisor: quotient zero
		send_instr(OP_MOD, 2, 7);  // negative divisor: dest kept
		send_instr(OP_DIV, 4, 5);  // divisor above dividend
		send_instr(OP_SUB, 6, 6);  // zero result, no borrow
		send_instr(OP_ADD, 7, 7);  // unsigned carry out
		send_instr(OP_ADD, 0, 0);
		send_instr(OP_ADD, 0, 0);
		send_instr(OP_ADD, 0, 0);  // positive + positive wraps negative
		send_instr(OP_ADD, 0, 0);  // negative + negative: carry and overflow
		send_instr(OP_MUL, 1, 1);  // large positive product
		send_instr(OP_MUL, 7, 5);  // small negative product fits
		send_instr(OP_MUL, 3, 7);  // zero times negative
		send_instr(OP_MUL, 7, 3);  // negative times zero
	endtask

	// Opcodes outside the arithmetic set, the end marker among them.
	task automatic test_noop_and_end();
		send_instr(opcode_t'(8'h00), 7, 7);
		send_instr(opcode_t'(8'h01), 0, 0);
		send_instr(opcode_t'(8'h07), 3, 4);
		send_instr(OP_END, 7, 0);
		send_instr(opcode_t'(8'hFF), 0, 7);
	endtask

	// Random program: mostly arithmetic with random registers, some end markers and
	// arbitrary opcodes. A stretch in the middle runs with no idling, and the sender
	// drains the pipe now and then.
	task automatic test_random_program(int count);
		opcode_t op;
		int      pick;
		for (int n = 0; n < count; n++) begin
			steady = (n >= count / 3) && (n < count / 3 + 100);
			pick = $urandom_range(99, 0);
			if (pick < 20)      op = OP_ADD;
			else if (pick < 40) op = OP_SUB;
			else if (pick < 55) op = OP_MUL;
			else if (pick < 68) op = OP_DIV;
			else if (pick < 81) op = OP_MOD;
			else if (pick < 86) op = OP_END;
			else                op = opcode_t'($urandom);
			send_instr(op, reg_field_t'($urandom), reg_field_t'($urandom));
			if (n % 120 == 119)
				hold_until_drained();
		end
		steady = 1'b0;
	endtask

	initial begin
		load_power_on_state();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_arith_corners();
		test_noop_and_end();
		hold_until_drained();
		test_random_program(RANDOM_ITEMS);

		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: files.f
hdl/rawf_pkg.sv
hdl/rawf_ram.sv
hdl/rawf_exec.sv
hdl/register_alu_with_flags_unit.sv
hdl/rawf_check.sv
tb/sv/register_alu_with_flags_unit_tb.sv
